// File: hdl/udr_pkg.sv
`timescale 1ns / 1ps

package udr_pkg;

  // operand width selector carried with each request
  typedef enum logic [1:0] {
    CMD_W8   = 2'd0,
    CMD_W16  = 2'd1,
    CMD_WMAX = 2'd2
  } udr_cmd_e;

  // narrow operand widths
  localparam int unsigned NARROW8_BITS  = 8;
  localparam int unsigned NARROW16_BITS = 16;

endpackage

// File: hdl/udr_if.sv
`timescale 1ns / 1ps

// operand request channel
interface udr_req_if #(
  parameter int unsigned W = 32
);
  import udr_pkg::*;

  logic         valid;
  logic         ready;
  udr_cmd_e     command;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;

  modport source (output valid, command, dividend, divisor, input ready);
  modport sink   (input valid, command, dividend, divisor, output ready);
endinterface

// result channel
interface udr_rsp_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic         div_by_zero;

  modport source (output valid, quotient, remainder, div_by_zero, input ready);
  modport sink   (input valid, quotient, remainder, div_by_zero, output ready);
endinterface

// File: hdl/udr_cell.sv
`timescale 1ns / 1ps

module udr_cell #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  udr_pkg::udr_cmd_e   cmd_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        acc_i,
  input  logic [W-1:0]        dvs_i,
  output logic                valid_o,
  output udr_pkg::udr_cmd_e   cmd_o,
  output logic [W-1:0]        rem_o,
  output logic [W-1:0]        acc_o,
  output logic [W-1:0]        dvs_o
);
  import udr_pkg::*;

  logic              valid_q;
  udr_cmd_e          cmd_q;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      acc_q, acc_d;
  logic [W-1:0]      dvs_q;
  logic [W:0]        shifted;
  logic [W:0]        diff;
  logic              ge;

  // one restoring step: bring in the next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_i, acc_i[W-1]};
    diff    = shifted - {1'b0, dvs_i};
    ge      = ~diff[W];
    rem_d   = ge ? diff[W-1:0] : shifted[W-1:0];
    acc_d   = {acc_i[W-2:0], ge};
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // step data
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_q <= cmd_i;
      rem_q <= rem_d;
      acc_q <= acc_d;
      dvs_q <= dvs_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign rem_o   = rem_q;
  assign acc_o   = acc_q;
  assign dvs_o   = dvs_q;

endmodule

// File: hdl/unsigned_divide_remainder.sv
`timescale 1ns / 1ps

// channel  | dir | payload                                  | handshake
// ---------+-----+------------------------------------------+------------
// in_i     | in  | command, dividend, divisor               | valid/ready
// out_o    | out | quotient, remainder, div_by_zero         | valid/ready
//
// one request per cycle while out_o is not stalled; each request passes through the chain of cells,
// one cell per quotient bit, each cell one trial subtraction
// rst_ni clears the valid flags of all cells; no data is reset
// a result waiting at the output with out_o.ready low holds the whole chain
// and drops in_i.ready; empty slots inside the chain are not squeezed out
module unsigned_divide_remainder #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  udr_req_if.sink     in_i,
  udr_rsp_if.source   out_o
);
  import udr_pkg::*;

  localparam int unsigned W = MAX_WIDTH;
  localparam logic [W-1:0] MASK8  = W'(64'((64'd1 << NARROW8_BITS) - 64'd1));
  localparam logic [W-1:0] MASK16 = W'(64'((64'd1 << NARROW16_BITS) - 64'd1));
  localparam logic [W-1:0] MASKW  = '1;

  logic         vld_s [0:W];
  udr_cmd_e     cmd_s [0:W];
  logic [W-1:0] rem_s [0:W];
  logic [W-1:0] acc_s [0:W];
  logic [W-1:0] dvs_s [0:W];
  logic [W-1:0] in_mask;
  logic [W-1:0] out_mask;
  logic         adv;

  // width mask from the selector; the reserved code takes the full width
  function automatic logic [W-1:0] sel_mask(input udr_cmd_e cmd);
    logic [W-1:0] m;
    case (cmd)
      CMD_W8:   m = MASK8;
      CMD_W16:  m = MASK16;
      CMD_WMAX: m = MASKW;
      default:  m = MASKW;
    endcase
    return m;
  endfunction

  // the chain moves whenever the last cell is empty or being drained
  assign adv       = ~vld_s[W] | out_o.ready;
  assign in_i.ready = adv;

  // feed the first cell with operands cut to the selected width
  assign in_mask  = sel_mask(in_i.command);
  assign vld_s[0] = in_i.valid;
  assign cmd_s[0] = in_i.command;
  assign rem_s[0] = '0;
  assign acc_s[0] = in_i.dividend & in_mask;
  assign dvs_s[0] = in_i.divisor & in_mask;

  // chain of restoring cells, one quotient bit each
  for (genvar k = 0; k < W; k++) begin : g_cell
    udr_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (vld_s[k]),
      .cmd_i   (cmd_s[k]),
      .rem_i   (rem_s[k]),
      .acc_i   (acc_s[k]),
      .dvs_i   (dvs_s[k]),
      .valid_o (vld_s[k+1]),
      .cmd_o   (cmd_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .acc_o   (acc_s[k+1]),
      .dvs_o   (dvs_s[k+1])
    );
  end

  // result; a zero divisor leaves all ones in the quotient, cut to width
  assign out_mask          = sel_mask(cmd_s[W]);
  assign out_o.valid       = vld_s[W];
  assign out_o.quotient    = acc_s[W] & out_mask;
  assign out_o.remainder   = rem_s[W];
  assign out_o.div_by_zero = (dvs_s[W] == '0);

`ifndef NO_ASSERTIONS
  // remainder stays below a nonzero divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.div_by_zero) |-> (out_o.remainder < dvs_s[W]))
    else $error("remainder not below divisor");

  // zero divisor gives all ones at the selected width
  a_dz_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.div_by_zero) |-> (out_o.quotient == out_mask))
    else $error("zero divisor quotient not all ones");

  // nothing above the selected width
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (((out_o.quotient | out_o.remainder) & ~out_mask) == '0))
    else $error("result bits above selected width");

  // a stalled result keeps its slot in the last cell
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_s[W] && !out_o.ready) |=> (vld_s[W] && $stable(acc_s[W])))
    else $error("stalled result lost");
`endif

endmodule

// File: verif/unsigned_divide_remainder_tb.sv
`timescale 1ns / 1ps

module unsigned_divide_remainder_tb;
  import udr_pkg::*;

  localparam int unsigned MAX_WIDTH  = 32;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam udr_cmd_e    CMD_RESERVED = udr_cmd_e'(2'd3);

  // one quotient/remainder pair as the block returns it
  typedef struct packed {
    logic [MAX_WIDTH-1:0] quotient;
    logic [MAX_WIDTH-1:0] remainder;
    logic                 div_by_zero;
  } division_t;

  // tracks outstanding divisions in request order
  class division_ledger;
    division_t   pending[$];
    int unsigned faults;

    function new();
      faults = 0;
    endfunction

    // work out the result of an accepted request and queue it
    function void log_operands(udr_cmd_e cmd, logic [MAX_WIDTH-1:0] dividend,
                               logic [MAX_WIDTH-1:0] divisor);
      int unsigned          bits;
      logic [63:0]          wide_mask;
      logic [MAX_WIDTH-1:0] mask, a, b;
      division_t            res;
      case (cmd)
        CMD_W8:  bits = NARROW8_BITS;
        CMD_W16: bits = NARROW16_BITS;
        default: bits = MAX_WIDTH;
      endcase
      wide_mask = (64'd1 << bits) - 64'd1;
      mask = wide_mask[MAX_WIDTH-1:0];
      a = dividend & mask;
      b = divisor & mask;
      if (b == '0) begin
        res.quotient    = mask;
        res.remainder   = a;
        res.div_by_zero = 1'b1;
      end else begin
        res.quotient    = a / b;
        res.remainder   = a % b;
        res.div_by_zero = 1'b0;
      end
      pending.push_back(res);
    endfunction

    // compare a returned result against the oldest outstanding division
    function void retire_result(logic [MAX_WIDTH-1:0] q, logic [MAX_WIDTH-1:0] r, logic dz);
      division_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding: q=%h r=%h dz=%b",
                 $time, q, r, dz);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (q !== want.quotient) begin
        $display("%0t: quotient mismatch: expected %h, actual %h", $time, want.quotient, q);
        faults++;
      end
      if (r !== want.remainder) begin
        $display("%0t: remainder mismatch: expected %h, actual %h", $time, want.remainder, r);
        faults++;
      end
      if (dz !== want.div_by_zero) begin
        $display("%0t: div_by_zero mismatch: expected %b, actual %b", $time,
                 want.div_by_zero, dz);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned hold_off_len = 0;
  bit          src_bursts = 1'b0;
  bit          sink_bursts = 1'b0;
  int unsigned quiet_cycles = 0;

  division_ledger ledger = new();

  udr_req_if #(.W(MAX_WIDTH)) req_ch ();
  udr_rsp_if #(.W(MAX_WIDTH)) rsp_ch ();

  unsigned_divide_remainder #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both channels; note requests, check results, catch hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        ledger.log_operands(req_ch.command, req_ch.dividend, req_ch.divisor);
      if (rsp_ch.valid && rsp_ch.ready)
        ledger.retire_result(rsp_ch.quotient, rsp_ch.remainder, rsp_ch.div_by_zero);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
          $display("unsigned_divide_remainder_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // result side: long hold when asked, random stall bursts when enabled, else always ready
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_off_len - 1) @(negedge clk_i);
        hold_off_len = 0;
      end else if (sink_bursts && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_division(udr_cmd_e cmd, logic [MAX_WIDTH-1:0] dividend,
                               logic [MAX_WIDTH-1:0] divisor);
    @(negedge clk_i);
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.dividend <= dividend;
    req_ch.divisor  <= divisor;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic pause_source(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    pause_source(1);
    while (ledger.pending.size() != 0) @(posedge clk_i);
  endtask

  // random operands with spread magnitudes and frequent zero divisors
  task automatic send_random_divisions(int unsigned count);
    logic [1:0]           sel;
    logic [MAX_WIDTH-1:0] a, b;
    repeat (count) begin
      if (src_bursts && $urandom_range(0, 7) == 0)
        pause_source($urandom_range(1, 17));
      sel = 2'($urandom_range(0, 3));
      a = $urandom;
      if ($urandom_range(0, 3) == 0)
        a = a >> $urandom_range(0, 31);
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = $urandom & 32'hFFFF_0000;
        2, 3, 4: b = $urandom >> $urandom_range(0, 31);
        5:       b = $urandom_range(1, 16);
        default: b = $urandom;
      endcase
      send_division(udr_cmd_e'(sel), a, b);
    end
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.command  = CMD_W8;
    req_ch.dividend = '0;
    req_ch.divisor  = '0;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero divisors at every width, extremes, ignored upper bits
    send_division(CMD_W8,       32'h0000_0000, 32'h0000_0000);
    send_division(CMD_W8,       32'h0000_00FF, 32'h0000_0000);
    send_division(CMD_W16,      32'h0000_FFFF, 32'h0000_0000);
    send_division(CMD_WMAX,     32'hFFFF_FFFF, 32'h0000_0000);
    send_division(CMD_RESERVED, 32'h1234_5678, 32'h0000_0000);
    send_division(CMD_W8,       32'hABCD_EF12, 32'h0000_0100);
    send_division(CMD_W16,      32'h8000_1234, 32'h5A5A_0000);
    send_division(CMD_W8,       32'hFFFF_FFFF, 32'h0000_0001);
    send_division(CMD_W16,      32'hFFFF_FFFF, 32'h0000_0001);
    send_division(CMD_WMAX,     32'hFFFF_FFFF, 32'h0000_0001);
    send_division(CMD_RESERVED, 32'hFFFF_FFFF, 32'h0000_0001);
    send_division(CMD_W8,       32'h0000_00FF, 32'h0000_00FF);
    send_division(CMD_WMAX,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_division(CMD_WMAX,     32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_division(CMD_WMAX,     32'h0000_0000, 32'h8000_0001);
    send_division(CMD_WMAX,     32'h8000_0000, 32'h0000_0002);
    send_division(CMD_W16,      32'h1234_FFFE, 32'hFFFF_00FF);
    send_division(CMD_W8,       32'h0000_00C8, 32'h0000_0007);
    send_division(CMD_W16,      32'hAAAA_5555, 32'h5555_AAAA);
    send_division(CMD_RESERVED, 32'hDEAD_BEEF, 32'h0001_0000);
    send_division(CMD_WMAX,     32'h5555_5555, 32'hAAAA_AAAA);
    send_division(CMD_W8,       32'h0000_007F, 32'h0000_0080);

    // random with gaps on both sides
    src_bursts  = 1'b1;
    sink_bursts = 1'b1;
    send_random_divisions(625);

    // result side holds off long enough to back up the whole chain
    src_bursts   = 1'b0;
    hold_off_len = HOLD_CYCLES;
    send_random_divisions(100);
    drain_results();

    src_bursts = 1'b1;
    send_random_divisions(500);

    // closing stretch at full rate
    src_bursts  = 1'b0;
    sink_bursts = 1'b0;
    send_random_divisions(300);
    drain_results();
    repeat (MAX_WIDTH + 8) @(posedge clk_i);

    if (ledger.faults == 0 && ledger.pending.size() == 0) begin
      $display("unsigned_divide_remainder_tb: PASS");
    end else begin
      $display("unsigned_divide_remainder_tb: FAIL");
    end
    $finish;
  end

endmodule
